/* src/lab_pkg.sv */
`timescale 1ns / 1ps
// Shared constants, item types and output rounding for the look-at basis unit.
package lab_pkg;

	// fixed-point formats
	localparam int COORD_FRAC_BITS = 16;
	localparam int OUT_FRAC_BITS   = 14;
	localparam int UNIT_FRAC       = 30;

	// widths
	localparam int COORD_W  = 32;
	localparam int DIR_W    = COORD_W + 1;
	localparam int UP_W     = COORD_W + 2;
	localparam int VEC_W    = COORD_W + 4;
	localparam int UNIT_W   = UNIT_FRAC + 2;
	localparam int OUT_W    = 16;
	localparam int EPS_W    = 16;
	localparam int SCL_W    = UNIT_FRAC + 1;
	localparam int SUM_W    = 2 * UNIT_W;
	localparam int LEN_W    = UNIT_W;

	// normalizer pipeline
	localparam int SQRT_STG = SUM_W / 2;
	localparam int DIV_STG  = SCL_W;
	localparam int NORM_LAT = 5 + SQRT_STG + DIV_STG + 1;

	// queue between front and back
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

	// output rounding
	localparam int RND_SH = UNIT_FRAC - OUT_FRAC_BITS;
	localparam logic signed [39:0] RND_ADD =
		(RND_SH > 0) ? (40'sd1 <<< ((RND_SH > 0) ? RND_SH - 1 : 0)) : 40'sd0;
	localparam logic signed [39:0] OUT_LIM = 40'sd1 <<< OUT_FRAC_BITS;

	typedef logic signed [VEC_W-1:0]  vec_t;
	typedef logic signed [UNIT_W-1:0] unit_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] src_x;
		logic signed [COORD_W-1:0] src_y;
		logic signed [COORD_W-1:0] src_z;
		logic signed [COORD_W-1:0] dst_x;
		logic signed [COORD_W-1:0] dst_y;
		logic signed [COORD_W-1:0] dst_z;
	} pts_t;

	typedef struct packed {
		logic signed [OUT_W-1:0] u_x;
		logic signed [OUT_W-1:0] u_y;
		logic signed [OUT_W-1:0] u_z;
		logic signed [OUT_W-1:0] v_x;
		logic signed [OUT_W-1:0] v_y;
		logic signed [OUT_W-1:0] v_z;
		logic signed [OUT_W-1:0] n_x;
		logic signed [OUT_W-1:0] n_y;
		logic signed [OUT_W-1:0] n_z;
		logic                    degenerate;
	} mat_t;

	// queued item: direction and target point
	typedef struct packed {
		logic signed [DIR_W-1:0]   dir_x;
		logic signed [DIR_W-1:0]   dir_y;
		logic signed [DIR_W-1:0]   dir_z;
		logic signed [COORD_W-1:0] dst_x;
		logic signed [COORD_W-1:0] dst_y;
		logic signed [COORD_W-1:0] dst_z;
	} entry_t;

	// round half up from Q1.30 to the output format, saturate to +-1.0
	function automatic logic signed [OUT_W-1:0] to_out(input vec_t x);
		logic signed [39:0] y;
		y = {{(40 - VEC_W){x[VEC_W-1]}}, x};
		y = (y + RND_ADD) >>> RND_SH;
		if (y > OUT_LIM) y = OUT_LIM;
		if (y < -OUT_LIM) y = -OUT_LIM;
		return y[OUT_W-1:0];
	endfunction

endpackage

/* src/lab_front.sv */
`timescale 1ns / 1ps
// Front end: accepts point items and forms the source-to-target direction.
module lab_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            pts_valid,
	output logic            pts_stall,
	input  lab_pkg::pts_t   pts,
	input  logic            full,
	output logic            push,
	output lab_pkg::entry_t entry
);

	logic            valid_s1;
	lab_pkg::entry_t entry_s1;
	lab_pkg::entry_t entry_c;
	logic signed [lab_pkg::DIR_W-1:0] sx, sy, sz, tx, ty, tz;

	assign push      = valid_s1 && !full;
	assign pts_stall = valid_s1 && full;
	assign entry     = entry_s1;

	// direction = target - source, exact in one extra bit
	always_comb begin
		sx = pts.src_x;
		sy = pts.src_y;
		sz = pts.src_z;
		tx = pts.dst_x;
		ty = pts.dst_y;
		tz = pts.dst_z;
		entry_c.dir_x = tx - sx;
		entry_c.dir_y = ty - sy;
		entry_c.dir_z = tz - sz;
		entry_c.dst_x = pts.dst_x;
		entry_c.dst_y = pts.dst_y;
		entry_c.dst_z = pts.dst_z;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!pts_stall) begin
			valid_s1 <= pts_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pts_valid && !pts_stall) begin
			entry_s1 <= entry_c;
		end
	end

endmodule

/* src/lab_fifo.sv */
`timescale 1ns / 1ps
// Short item queue between the front end and the back end.
module lab_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  lab_pkg::entry_t wdata,
	output logic            full,
	input  logic            pop,
	output lab_pkg::entry_t rdata,
	output logic            not_empty
);

	localparam int D  = lab_pkg::FIFO_DEPTH;
	localparam int AW = lab_pkg::FIFO_AW;

	logic [AW-1:0]   wp_q, rp_q;
	logic [AW:0]     cnt_q;
	lab_pkg::entry_t mem_q [D];

	assign full      = (cnt_q == (AW + 1)'(D));
	assign not_empty = (cnt_q != '0);
	assign rdata     = mem_q[rp_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 1'b1;
			if (pop) rp_q <= rp_q + 1'b1;
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (!push && pop) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= wdata;
	end

`ifndef SYNTHESIS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (AW + 1)'(D))
		else $error("queue count beyond depth");
	a_cnt_up: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> cnt_q == $past(cnt_q) + 1'b1)
		else $error("queue count did not follow a push");
	a_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> cnt_q != '0)
		else $error("pop from empty queue");
`endif

endmodule

/* src/lab_norm.sv */
`timescale 1ns / 1ps
// Pipelined vector normalizer: scale, sum of squares, square root, divide.
module lab_norm (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           in_valid,
	input  lab_pkg::vec_t  in_vec [3],
	output logic           out_valid,
	output lab_pkg::unit_t out_unit [3],
	output logic           out_nz
);

	localparam int MW  = lab_pkg::VEC_W;
	localparam int SW  = lab_pkg::SCL_W;
	localparam int XW  = lab_pkg::SUM_W;
	localparam int LW  = lab_pkg::LEN_W;
	localparam int RN  = lab_pkg::SQRT_STG;
	localparam int DN  = lab_pkg::DIV_STG;
	localparam int AW  = $clog2(MW);
	localparam int TOP = SW - 1;

	// stage 1: magnitudes and largest
	logic [MW-1:0] mag_c [3];
	logic [MW-1:0] big_c;
	logic          v_s1;
	logic [MW-1:0] m_s1 [3];
	logic [2:0]    sg_s1;
	logic [MW-1:0] big_s1;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			mag_c[i] = in_vec[i][MW-1] ? (~in_vec[i] + 1'b1) : in_vec[i];
		end
		big_c = mag_c[0];
		if (mag_c[1] > big_c) big_c = mag_c[1];
		if (mag_c[2] > big_c) big_c = mag_c[2];
	end

	// stage 2: shift to bring the largest into [2^30, 2^31)
	logic [AW-1:0] msb_c;
	logic          v_s2;
	logic [MW-1:0] m_s2 [3];
	logic [2:0]    sg_s2;
	logic          dn_s2;
	logic [AW-1:0] amt_s2;
	logic          zr_s2;

	always_comb begin
		msb_c = '0;
		for (int b = 0; b < MW; b++) begin
			if (big_s1[b]) msb_c = AW'(b);
		end
	end

	// stage 3: scaled magnitudes
	logic [MW-1:0] sh_c [3];
	logic          v_s3;
	logic [SW-1:0] ms_s3 [3];
	logic [2:0]    sg_s3;
	logic          zr_s3;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			sh_c[i] = dn_s2 ? (m_s2[i] >> amt_s2) : (m_s2[i] << amt_s2);
		end
	end

	// stage 4: squares
	logic              v_s4;
	logic [2*SW-1:0]   sq_s4 [3];
	logic [SW-1:0]     ms_s4 [3];
	logic [2:0]        sg_s4;
	logic              zr_s4;

	// square root pipeline, element 0 holds the sum of squares
	logic [XW-1:0] rx_q  [RN+1];
	logic [XW-1:0] rr_q  [RN+1];
	logic [SW-1:0] rms_q [RN+1][3];
	logic [2:0]    rsg_q [RN+1];
	logic          rzr_q [RN+1];
	logic          rv_q  [RN+1];
	logic [XW-1:0] rx_n  [RN];
	logic [XW-1:0] rr_n  [RN];
	logic [XW-1:0] bit_c [RN];
	logic [XW-1:0] tr_c  [RN];

	always_comb begin
		for (int k = 0; k < RN; k++) begin
			bit_c[k] = XW'(1) << (XW - 2 - 2 * k);
			tr_c[k]  = rr_q[k] + bit_c[k];
			if (rx_q[k] >= tr_c[k]) begin
				rx_n[k] = rx_q[k] - tr_c[k];
				rr_n[k] = (rr_q[k] >> 1) + bit_c[k];
			end else begin
				rx_n[k] = rx_q[k];
				rr_n[k] = rr_q[k] >> 1;
			end
		end
	end

	// divider pipeline, one quotient bit per stage and lane
	logic [LW-1:0] dr_q [DN][3];
	logic [SW-1:0] dq_q [DN][3];
	logic [LW-1:0] dl_q [DN];
	logic [2:0]    dsg_q [DN];
	logic          dzr_q [DN];
	logic          dv_q  [DN];
	logic [LW-1:0] dr_n [DN][3];
	logic [SW-1:0] dq_n [DN][3];
	logic [LW-1:0] len_c [DN];
	logic [LW-1:0] rin_c [DN][3];
	logic [SW-1:0] qin_c [DN][3];
	logic          db_c  [DN][3];
	logic [LW:0]   cat_c [DN][3];
	logic [LW:0]   dif_c [DN][3];
	logic          ge_c  [DN][3];

	always_comb begin
		for (int j = 0; j < DN; j++) begin
			len_c[j] = (j == 0) ? rr_q[RN][LW-1:0] : dl_q[(j == 0) ? 0 : j - 1];
			for (int l = 0; l < 3; l++) begin
				if (j == 0) begin
					rin_c[j][l] = LW'(rms_q[RN][l] >> 1);
					db_c[j][l]  = rms_q[RN][l][0];
					qin_c[j][l] = '0;
				end else begin
					rin_c[j][l] = dr_q[(j == 0) ? 0 : j - 1][l];
					db_c[j][l]  = 1'b0;
					qin_c[j][l] = dq_q[(j == 0) ? 0 : j - 1][l];
				end
				cat_c[j][l] = {rin_c[j][l], db_c[j][l]};
				dif_c[j][l] = cat_c[j][l] - {1'b0, len_c[j]};
				ge_c[j][l]  = cat_c[j][l] >= {1'b0, len_c[j]};
				dr_n[j][l]  = ge_c[j][l] ? dif_c[j][l][LW-1:0] : cat_c[j][l][LW-1:0];
				dq_n[j][l]  = {qin_c[j][l][SW-2:0], ge_c[j][l]};
			end
		end
	end

	// final sign
	logic           v_o;
	lab_pkg::unit_t u_o [3];
	logic           nz_o;

	assign out_valid = v_o;
	assign out_unit  = u_o;
	assign out_nz    = nz_o;

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			for (int k = 0; k <= RN; k++) rv_q[k] <= 1'b0;
			for (int j = 0; j < DN; j++) dv_q[j] <= 1'b0;
			v_o <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			rv_q[0] <= v_s4;
			for (int k = 0; k < RN; k++) rv_q[k+1] <= rv_q[k];
			dv_q[0] <= rv_q[RN];
			for (int j = 1; j < DN; j++) dv_q[j] <= dv_q[j-1];
			v_o <= dv_q[DN-1];
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				m_s1[i]  <= mag_c[i];
				sg_s1[i] <= in_vec[i][MW-1];
			end
			big_s1 <= big_c;

			m_s2   <= m_s1;
			sg_s2  <= sg_s1;
			dn_s2  <= (msb_c > AW'(TOP));
			amt_s2 <= (msb_c > AW'(TOP)) ? (msb_c - AW'(TOP)) : (AW'(TOP) - msb_c);
			zr_s2  <= (big_s1 == '0);

			for (int i = 0; i < 3; i++) ms_s3[i] <= sh_c[i][SW-1:0];
			sg_s3 <= sg_s2;
			zr_s3 <= zr_s2;

			for (int i = 0; i < 3; i++) sq_s4[i] <= ms_s3[i] * ms_s3[i];
			ms_s4 <= ms_s3;
			sg_s4 <= sg_s3;
			zr_s4 <= zr_s3;

			rx_q[0]  <= XW'(sq_s4[0]) + XW'(sq_s4[1]) + XW'(sq_s4[2]);
			rr_q[0]  <= '0;
			rms_q[0] <= ms_s4;
			rsg_q[0] <= sg_s4;
			rzr_q[0] <= zr_s4;
			for (int k = 0; k < RN; k++) begin
				rx_q[k+1]  <= rx_n[k];
				rr_q[k+1]  <= rr_n[k];
				rms_q[k+1] <= rms_q[k];
				rsg_q[k+1] <= rsg_q[k];
				rzr_q[k+1] <= rzr_q[k];
			end

			for (int j = 0; j < DN; j++) begin
				dr_q[j] <= dr_n[j];
				dq_q[j] <= dq_n[j];
				dl_q[j] <= len_c[j];
			end
			dsg_q[0] <= rsg_q[RN];
			dzr_q[0] <= rzr_q[RN];
			for (int j = 1; j < DN; j++) begin
				dsg_q[j] <= dsg_q[j-1];
				dzr_q[j] <= dzr_q[j-1];
			end

			for (int i = 0; i < 3; i++) begin
				if (dzr_q[DN-1]) u_o[i] <= '0;
				else if (dsg_q[DN-1][i]) u_o[i] <= -$signed({1'b0, dq_q[DN-1][i]});
				else u_o[i] <= $signed({1'b0, dq_q[DN-1][i]});
			end
			nz_o <= !dzr_q[DN-1];
		end
	end

endmodule

/* src/lab_back.sv */
`timescale 1ns / 1ps
// Back end: normalizes N, picks the up point, builds V and U, rounds the matrix.
module lab_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [lab_pkg::EPS_W-1:0]   eps,
	input  logic                        entry_valid,
	input  lab_pkg::entry_t             entry,
	output logic                        pop,
	output logic                        mat_valid,
	input  logic                        mat_stall,
	output lab_pkg::mat_t               mat
);

	localparam int LAT = lab_pkg::NORM_LAT;
	localparam int UW  = lab_pkg::UP_W;
	localparam int NW  = lab_pkg::UNIT_W;
	localparam int PW  = UW + NW;
	localparam int DW  = UW + 4;
	localparam int CW  = UW + 1;
	localparam int QW  = CW + NW;
	localparam int VW  = lab_pkg::VEC_W;
	localparam int XW  = 2 * NW;
	localparam int SH  = lab_pkg::UNIT_FRAC;
	localparam int CFB = lab_pkg::COORD_FRAC_BITS;
	localparam logic signed [UW-1:0] ONE_C = UW'(1) << CFB;
	localparam logic signed [DW-1:0] DLIM  = DW'(1) << (UW - 1);

	typedef struct packed {
		logic signed [lab_pkg::COORD_W-1:0] x;
		logic signed [lab_pkg::COORD_W-1:0] y;
		logic signed [lab_pkg::COORD_W-1:0] z;
	} dst_t;

	typedef struct packed {
		lab_pkg::unit_t nx;
		lab_pkg::unit_t ny;
		lab_pkg::unit_t nz;
		logic           nok;
		logic           fail;
	} side_t;

	logic en;
	assign en  = !(mat_valid && mat_stall);
	assign pop = en && entry_valid;

	// first normalizer: direction to N
	lab_pkg::vec_t  na_vec [3];
	logic           na_valid;
	lab_pkg::unit_t na_unit [3];
	logic           na_nz;

	assign na_vec[0] = entry.dir_x;
	assign na_vec[1] = entry.dir_y;
	assign na_vec[2] = entry.dir_z;

	lab_norm u_norm_n (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (pop),
		.in_vec   (na_vec),
		.out_valid(na_valid),
		.out_unit (na_unit),
		.out_nz   (na_nz)
	);

	// target point travels beside the normalizer
	dst_t dst_dl_s [LAT];
	always_ff @(posedge clk) begin
		if (en) begin
			dst_dl_s[0] <= '{x: entry.dst_x, y: entry.dst_y, z: entry.dst_z};
			for (int k = 1; k < LAT; k++) dst_dl_s[k] <= dst_dl_s[k-1];
		end
	end

	// stage 1: both up points minus target, dot product terms
	logic signed [UW-1:0] v0x_c, v0y_c, v1x_c, v1y_c, vz_c;
	dst_t                 dd;
	assign dd = dst_dl_s[LAT-1];
	always_comb begin
		v0x_c = -dd.x;
		v0y_c = ONE_C - dd.y;
		v1x_c = ONE_C - dd.x;
		v1y_c = -dd.y;
		vz_c  = -dd.z;
	end

	logic                 va_s1;
	logic signed [UW-1:0] v0x_s1, v0y_s1, v1x_s1, v1y_s1, vz_s1;
	logic signed [PW-1:0] p0_s1 [3];
	logic signed [PW-1:0] p1_s1 [3];
	lab_pkg::unit_t       n_s1 [3];
	logic                 nok_s1;

	// stage 2: dot sums
	logic signed [PW-1:0] t0_c [3];
	logic signed [PW-1:0] t1_c [3];
	logic signed [PW-1:0] sum0_c, sum1_c;
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			t0_c[i] = p0_s1[i] >>> SH;
			t1_c[i] = p1_s1[i] >>> SH;
		end
		sum0_c = t0_c[0] + t0_c[1] + t0_c[2];
		sum1_c = t1_c[0] + t1_c[1] + t1_c[2];
	end

	logic                 va_s2;
	logic signed [DW-1:0] dot0_s2, dot1_s2;
	logic signed [UW-1:0] v0x_s2, v0y_s2, v1x_s2, v1y_s2, vz_s2;
	lab_pkg::unit_t       n_s2 [3];
	logic                 nok_s2;

	// stage 3: near-zero test, up point choice, clamp
	logic [DW-1:0] mag0_c, mag1_c;
	logic [63:0]   eps_c;
	logic          z0_c, z1_c;
	logic signed [DW-1:0] dsel_c;
	always_comb begin
		mag0_c = dot0_s2[DW-1] ? (~dot0_s2 + 1'b1) : dot0_s2;
		mag1_c = dot1_s2[DW-1] ? (~dot1_s2 + 1'b1) : dot1_s2;
		eps_c  = 64'(eps) << CFB;
		z0_c   = ((64'(mag0_c) << 16) < eps_c);
		z1_c   = ((64'(mag1_c) << 16) < eps_c);
		dsel_c = z0_c ? dot1_s2 : dot0_s2;
		if (dsel_c > DLIM) dsel_c = DLIM;
		if (dsel_c < -DLIM) dsel_c = -DLIM;
	end

	logic                 va_s3;
	logic signed [CW-1:0] dot_s3;
	logic signed [UW-1:0] vx_s3, vy_s3, vz_s3;
	lab_pkg::unit_t       n_s3 [3];
	logic                 nok_s3, fail_s3;

	// stage 4: projection terms
	logic                 va_s4;
	logic signed [QW-1:0] pd_s4 [3];
	logic signed [UW-1:0] vx_s4, vy_s4, vz_s4;
	lab_pkg::unit_t       n_s4 [3];
	logic                 nok_s4, fail_s4;

	// stage 5: V with the N part removed
	logic signed [QW-1:0] vx_w, vy_w, vz_w;
	always_comb begin
		vx_w = vx_s4;
		vy_w = vy_s4;
		vz_w = vz_s4;
		vx_w = vx_w - (pd_s4[0] >>> SH);
		vy_w = vy_w - (pd_s4[1] >>> SH);
		vz_w = vz_w - (pd_s4[2] >>> SH);
	end

	logic           va_s5;
	lab_pkg::vec_t  vn_s5 [3];
	side_t          side_s5;

	// second normalizer: V
	logic           nb_valid;
	lab_pkg::unit_t nb_unit [3];
	logic           nb_nz;

	lab_norm u_norm_v (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (va_s5),
		.in_vec   (vn_s5),
		.out_valid(nb_valid),
		.out_unit (nb_unit),
		.out_nz   (nb_nz)
	);

	side_t side_dl_s [LAT];
	always_ff @(posedge clk) begin
		if (en) begin
			side_dl_s[0] <= side_s5;
			for (int k = 1; k < LAT; k++) side_dl_s[k] <= side_dl_s[k-1];
		end
	end

	side_t sd;
	assign sd = side_dl_s[LAT-1];

	// stage 6: cross product terms
	logic                 vb_s6;
	logic signed [XW-1:0] ca_s6 [3];
	logic signed [XW-1:0] cb_s6 [3];
	lab_pkg::unit_t       vu_s6 [3];
	lab_pkg::unit_t       n_s6 [3];
	logic                 deg_s6;

	// stage 7: U
	logic signed [XW-1:0] cd_c [3];
	always_comb begin
		for (int i = 0; i < 3; i++) cd_c[i] = (ca_s6[i] - cb_s6[i]) >>> SH;
	end

	logic           vb_s7;
	lab_pkg::vec_t  u_s7 [3];
	lab_pkg::unit_t vu_s7 [3];
	lab_pkg::unit_t n_s7 [3];
	logic           deg_s7;

	// stage 8: output register
	logic          valid_s8;
	lab_pkg::mat_t mat_s8;

	assign mat_valid = valid_s8;
	assign mat       = mat_s8;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			va_s1    <= 1'b0;
			va_s2    <= 1'b0;
			va_s3    <= 1'b0;
			va_s4    <= 1'b0;
			va_s5    <= 1'b0;
			vb_s6    <= 1'b0;
			vb_s7    <= 1'b0;
			valid_s8 <= 1'b0;
		end else if (en) begin
			va_s1    <= na_valid;
			va_s2    <= va_s1;
			va_s3    <= va_s2;
			va_s4    <= va_s3;
			va_s5    <= va_s4;
			vb_s6    <= nb_valid;
			vb_s7    <= vb_s6;
			valid_s8 <= vb_s7;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (en) begin
			v0x_s1 <= v0x_c;
			v0y_s1 <= v0y_c;
			v1x_s1 <= v1x_c;
			v1y_s1 <= v1y_c;
			vz_s1  <= vz_c;
			p0_s1[0] <= v0x_c * na_unit[0];
			p0_s1[1] <= v0y_c * na_unit[1];
			p0_s1[2] <= vz_c * na_unit[2];
			p1_s1[0] <= v1x_c * na_unit[0];
			p1_s1[1] <= v1y_c * na_unit[1];
			p1_s1[2] <= vz_c * na_unit[2];
			n_s1   <= na_unit;
			nok_s1 <= na_nz;

			dot0_s2 <= sum0_c[DW-1:0];
			dot1_s2 <= sum1_c[DW-1:0];
			v0x_s2  <= v0x_s1;
			v0y_s2  <= v0y_s1;
			v1x_s2  <= v1x_s1;
			v1y_s2  <= v1y_s1;
			vz_s2   <= vz_s1;
			n_s2    <= n_s1;
			nok_s2  <= nok_s1;

			dot_s3  <= dsel_c[CW-1:0];
			vx_s3   <= z0_c ? v1x_s2 : v0x_s2;
			vy_s3   <= z0_c ? v1y_s2 : v0y_s2;
			vz_s3   <= vz_s2;
			n_s3    <= n_s2;
			nok_s3  <= nok_s2;
			fail_s3 <= z0_c && z1_c;

			for (int i = 0; i < 3; i++) pd_s4[i] <= dot_s3 * n_s3[i];
			vx_s4   <= vx_s3;
			vy_s4   <= vy_s3;
			vz_s4   <= vz_s3;
			n_s4    <= n_s3;
			nok_s4  <= nok_s3;
			fail_s4 <= fail_s3;

			vn_s5[0] <= vx_w[VW-1:0];
			vn_s5[1] <= vy_w[VW-1:0];
			vn_s5[2] <= vz_w[VW-1:0];
			side_s5  <= '{nx: n_s4[0], ny: n_s4[1], nz: n_s4[2],
				nok: nok_s4, fail: fail_s4};

			ca_s6[0] <= nb_unit[1] * sd.nz;
			cb_s6[0] <= nb_unit[2] * sd.ny;
			ca_s6[1] <= nb_unit[2] * sd.nx;
			cb_s6[1] <= nb_unit[0] * sd.nz;
			ca_s6[2] <= nb_unit[0] * sd.ny;
			cb_s6[2] <= nb_unit[1] * sd.nx;
			vu_s6    <= nb_unit;
			n_s6[0]  <= sd.nx;
			n_s6[1]  <= sd.ny;
			n_s6[2]  <= sd.nz;
			deg_s6   <= sd.fail || !sd.nok;

			for (int i = 0; i < 3; i++) u_s7[i] <= cd_c[i][VW-1:0];
			vu_s7  <= vu_s6;
			n_s7   <= n_s6;
			deg_s7 <= deg_s6;

			mat_s8.u_x <= lab_pkg::to_out(u_s7[0]);
			mat_s8.u_y <= lab_pkg::to_out(u_s7[1]);
			mat_s8.u_z <= lab_pkg::to_out(u_s7[2]);
			mat_s8.v_x <= lab_pkg::to_out(vu_s7[0]);
			mat_s8.v_y <= lab_pkg::to_out(vu_s7[1]);
			mat_s8.v_z <= lab_pkg::to_out(vu_s7[2]);
			mat_s8.n_x <= lab_pkg::to_out(n_s7[0]);
			mat_s8.n_y <= lab_pkg::to_out(n_s7[1]);
			mat_s8.n_z <= lab_pkg::to_out(n_s7[2]);
			mat_s8.degenerate <= deg_s7;
		end
	end

`ifndef SYNTHESIS
	a_zero_n_deg: assert property (@(posedge clk) disable iff (!arst_n)
		mat_valid && mat.n_x == '0 && mat.n_y == '0 && mat.n_z == '0 |-> mat.degenerate)
		else $error("zero N row without degenerate flag");
	a_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		mat_valid && mat_stall |=> $stable(va_s5) && $stable(vb_s7))
		else $error("back pipeline moved while output stalled");
`endif

endmodule

/* src/look_at_basis_unit.sv */
`timescale 1ns / 1ps
// Top level of the look-at basis unit: config register, front end, queue, back end.
//
//  channel  | signals                      | direction | payload
//  ---------+------------------------------+-----------+---------------------------
//  pts      | pts_valid, pts_stall, pts    | in        | source and target, Q15.16
//  mat      | mat_valid, mat_stall, mat    | out       | U, V, N rows Q1.14, flag
//  eps      | eps_we, eps_wdata            | in        | dot epsilon, Q0.16
//
// One item per cycle sustained while the output is not stalled; the total delay is set by the two
// normalizer pipelines (32-step square root and 31-step divider each).
// Reset clears all valid bits and the queue and sets the epsilon to 66.
// A stalled output freezes the back end; the four-entry queue and the front
// register keep taking items until they fill.
module look_at_basis_unit (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      pts_valid,
	output logic                      pts_stall,
	input  lab_pkg::pts_t             pts,
	output logic                      mat_valid,
	input  logic                      mat_stall,
	output lab_pkg::mat_t             mat,
	input  logic                      eps_we,
	input  logic [lab_pkg::EPS_W-1:0] eps_wdata
);

	logic [lab_pkg::EPS_W-1:0] eps_q;
	logic                      push, full, pop, not_empty;
	lab_pkg::entry_t           wdata, rdata;

	// epsilon register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eps_q <= lab_pkg::EPS_W'(66);
		end else if (eps_we) begin
			eps_q <= eps_wdata;
		end
	end

	lab_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.pts_valid(pts_valid),
		.pts_stall(pts_stall),
		.pts      (pts),
		.full     (full),
		.push     (push),
		.entry    (wdata)
	);

	lab_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wdata    (wdata),
		.full     (full),
		.pop      (pop),
		.rdata    (rdata),
		.not_empty(not_empty)
	);

	lab_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.eps        (eps_q),
		.entry_valid(not_empty),
		.entry      (rdata),
		.pop        (pop),
		.mat_valid  (mat_valid),
		.mat_stall  (mat_stall),
		.mat        (mat)
	);

endmodule
